/* sv/sau_pkg.sv */
// ----------------------------------------------------------------------------
// sau_pkg
// shared types and constants of the stack allocator unit
// ----------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

  // sizing
  localparam int MAX_WORDS  = 16384;
  localparam int MAX_BLOCKS = 64;
  localparam int TOP_W      = $clog2(MAX_WORDS);        // word index below region end
  localparam int REGION_W   = 15;                       // region_words register
  localparam int IDX_W      = $clog2(MAX_BLOCKS);       // link stack address
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);   // live block count

  // opcodes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_LINK_FULL = 3'd4;

  // register index of region_words
  localparam logic REG_REGION = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch a new transaction, start first link read
    logic walk_next;  // step the remove walk one block older
    logic walk_hit;   // remove found its block
    logic commit;     // update state and load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;   // no live blocks
    logic hit;        // link entry under the walk matches the offset
    logic idx_zero;   // walk is at the oldest block
    logic out_free;   // result register can take a new transaction
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/stack_allocator_unit.sv */
// ----------------------------------------------------------------------------
// stack_allocator_unit
// work-space stack allocator with mark and release over a word region
// ----------------------------------------------------------------------------
// sequence: push, pop and query go from accept straight to the commit, which loads
//   the result register once it is free; remove first walks link entries, newest first
// flow: one transaction at a time; the link stack read port sets the remove walk speed
// reset: synchronous, clears top, block count, output valid and region size
//   (16384 words); link stack contents are not cleared, never read unwritten
// ----------------------------------------------------------------------------
`default_nettype none

module stack_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] request_bytes,
  input  wire logic [15:0] block_offset,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [15:0]      granted_offset,
  output logic [16:0]      free_bytes,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sau_pkg::*;

  logic [REGION_W-1:0] region_words;
  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic                cfg_wr;

  // configuration: region size register at byte address 0, zero-wait access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_REGION);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_words <= REGION_W'(MAX_WORDS);
    end else if (cfg_wr) begin
      region_words <= pwdata[REGION_W-1:0];
    end
  end

  // read back, addresses past the register read as zero
  assign prdata = (paddr[2] == REG_REGION) ? {{(32-REGION_W){1'b0}}, region_words} : '0;

  // controller: sequences accept, the remove walk and the commit of a result
  sau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: allocator state, link stack memory and the result register,
  // which holds a finished transaction while the next one is accepted
  sau_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .request_bytes  (request_bytes),
    .block_offset   (block_offset),
    .region_words   (region_words),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .granted_offset (granted_offset),
    .free_bytes     (free_bytes)
  );

`ifndef SYNTH
  // only a successful transaction carries a granted offset
  a_granted_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (granted_offset == 16'd0))
    else $error("granted offset on a failed transaction");

  // free space is whole words
  a_free_word_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_bytes[1:0] == 2'b00))
    else $error("free bytes not word aligned");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a transaction while busy");

  // a result appears only after a commit of the controller
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result register loaded without a commit");
`endif

endmodule

`default_nettype wire

/* sv/sau_ram.sv */
// ----------------------------------------------------------------------------
// sau_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sau_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/sau_dp.sv */
// ----------------------------------------------------------------------------
// sau_dp
// allocator datapath: top and count registers, link stack, result register
// ----------------------------------------------------------------------------
`default_nettype none

module sau_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sau_pkg::dp_cmd_t   cmd,
  output sau_pkg::dp_stat_t       stat,
  input  wire logic [1:0]         opcode,
  input  wire logic [15:0]        request_bytes,
  input  wire logic [15:0]        block_offset,
  input  wire logic [sau_pkg::REGION_W-1:0] region_words,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [2:0]              status,
  output logic [15:0]             granted_offset,
  output logic [16:0]             free_bytes
);
  import sau_pkg::*;

  logic [TOP_W-1:0]    top;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    idx;
  logic                found;
  logic [1:0]          op_q;
  logic [15:0]         req_q;
  logic [15:0]         offs_q;

  logic [TOP_W-1:0]    top_next;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    cnt_m1;
  logic [REGION_W-1:0] reff;
  logic [16:0]         bytes_rnd;
  logic [REGION_W-1:0] words;
  logic [15:0]         new_end;
  logic                fits;
  logic [2:0]          res_status;
  logic [15:0]         res_granted;
  logic [16:0]         res_free;
  logic [REGION_W-1:0] diff;

  logic                wr_en;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [TOP_W-1:0]    rd_data;

  sau_ram #(
    .WIDTH (TOP_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (top),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cnt_m1  = count - CNT_W'(1);
  assign rd_en   = (cmd.accept && (count != '0)) || cmd.walk_next;
  assign rd_addr = cmd.accept ? cnt_m1[IDX_W-1:0] : idx - IDX_W'(1);

  assign stat.cnt_zero = (count == '0);
  assign stat.hit      = (rd_data == offs_q[15:2]) && (offs_q[1:0] == 2'b00);
  assign stat.idx_zero = (idx == '0);
  assign stat.out_free = !out_valid || out_ready;

  // effective region, clipped to the physical size
  assign reff = (region_words > REGION_W'(MAX_WORDS)) ? REGION_W'(MAX_WORDS) : region_words;

  // request plus 12 bookkeeping bytes, rounded up to 8, in words
  assign bytes_rnd = {1'b0, req_q} + 17'd19;
  assign words     = {bytes_rnd[16:3], 1'b0};
  assign new_end   = {2'b00, top} + {1'b0, words};
  assign fits      = new_end < {1'b0, reff};

  always_comb begin
    top_next    = top;
    count_next  = count;
    res_status  = ST_OK;
    res_granted = '0;
    wr_en       = 1'b0;
    case (op_q)
      OP_PUSH: begin
        if (!fits) begin
          res_status = ST_EXHAUSTED;
        end else if (count == CNT_W'(MAX_BLOCKS)) begin
          res_status = ST_LINK_FULL;
        end else begin
          wr_en       = cmd.commit;
          top_next    = new_end[TOP_W-1:0];
          count_next  = count + CNT_W'(1);
          res_granted = {top, 2'b00};
        end
      end
      OP_POP: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          top_next   = rd_data;
          count_next = cnt_m1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          top_next   = rd_data;
          count_next = {1'b0, idx};
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    diff     = reff - {1'b0, top_next};
    res_free = ({1'b0, top_next} < reff) ? {diff, 2'b00} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= '0;
      count     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        found <= 1'b0;
      end else if (cmd.walk_hit) begin
        found <= 1'b1;
      end
      if (cmd.commit) begin
        top       <= top_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= opcode;
      req_q  <= request_bytes;
      offs_q <= block_offset;
      idx    <= cnt_m1[IDX_W-1:0];
    end else if (cmd.walk_next) begin
      idx <= idx - IDX_W'(1);
    end
    if (cmd.commit) begin
      status         <= res_status;
      granted_offset <= res_granted;
      free_bytes     <= res_free;
    end
  end

endmodule

`default_nettype wire

/* sv/sau_ctrl.sv */
// ----------------------------------------------------------------------------
// sau_ctrl
// allocator controller: accept, remove walk, result commit
// ----------------------------------------------------------------------------
`default_nettype none

module sau_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       opcode,
  input  wire sau_pkg::dp_stat_t stat,
  output sau_pkg::dp_cmd_t      cmd
);
  import sau_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (opcode == OP_REMOVE && !stat.cnt_zero) begin
            state_next = S_WALK;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_WALK: begin
        // one link entry examined per cycle, newest first
        if (stat.hit) begin
          cmd.walk_hit = 1'b1;
          state_next   = S_FINISH;
        end else if (stat.idx_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the stack allocator unit result by result against a shadow model
// of its top, block count and link stack, under random handshake idling
// ----------------------------------------------------------------------------

module testbench;
  import sau_pkg::*;

  // shadow copies: one tracks the stream as it is planned, one as the
  // dut accepts it
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  localparam logic [2:0] REGION_ADDR = {REG_REGION, 2'b00};
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 260;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] req;
    logic [15:0] offs;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted;
    logic [16:0] free;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_QUERY;
  logic [15:0] request_bytes = '0;
  logic [15:0] block_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] granted_offset;
  logic [16:0] free_bytes;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stack_allocator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .request_bytes(request_bytes), .block_offset(block_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .granted_offset(granted_offset), .free_bytes(free_bytes),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 100 MHz
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator shadow state, two copies
  int unsigned shadow_region [2];
  int unsigned shadow_top    [2];
  int unsigned shadow_count  [2];
  logic [13:0] shadow_links  [2][MAX_BLOCKS];

  alloc_req_t alloc_requests[$];    // planned transactions not yet offered
  alloc_rsp_t expected_replies[$];  // predicted results not yet seen
  alloc_req_t offered_req;          // transaction currently on the input

  int n_added = 0;     // transactions planned
  int n_done = 0;      // results compared
  int n_errors = 0;
  int n_settings = 0;
  int status_seen [5];

  int src_idle_pct = 37;
  int snk_idle_pct = 79;
  logic hold_armed = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   stall_cycles = 0;

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // one transaction applied to shadow copy c; returns the predicted result
  function automatic alloc_rsp_t alloc_step(input int c, input alloc_req_t r);
    alloc_rsp_t  o;
    int unsigned lim;
    int unsigned words;
    int unsigned i;
    bit          hit;
    o = '0;
    o.status = ST_OK;
    lim = (shadow_region[c] > MAX_WORDS) ? MAX_WORDS : shadow_region[c];
    case (r.op)
      OP_PUSH: begin
        // 12 bytes of bookkeeping, rounded up to 8 bytes, counted in words
        words = ((32'(r.req) + 32'd19) & ~32'd7) >> 2;
        if (shadow_top[c] + words >= lim) begin
          o.status = ST_EXHAUSTED;
        end else if (shadow_count[c] >= MAX_BLOCKS) begin
          o.status = ST_LINK_FULL;
        end else begin
          shadow_links[c][shadow_count[c]] = 14'(shadow_top[c]);
          shadow_count[c] = shadow_count[c] + 1;
          o.granted = 16'(shadow_top[c] * 4);
          shadow_top[c] = shadow_top[c] + words;
        end
      end
      OP_POP: begin
        if (shadow_count[c] == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shadow_count[c] = shadow_count[c] - 1;
          shadow_top[c] = shadow_links[c][shadow_count[c]];
        end
      end
      OP_REMOVE: begin
        // newest block first; the match and everything newer goes
        hit = 1'b0;
        for (i = shadow_count[c]; i > 0 && !hit; i--) begin
          if (32'(shadow_links[c][i-1]) * 4 == 32'(r.offs)) begin
            shadow_top[c] = shadow_links[c][i-1];
            shadow_count[c] = i - 1;
            hit = 1'b1;
          end
        end
        if (!hit) o.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    if (shadow_top[c] >= lim) o.free = '0;
    else if ((lim - shadow_top[c]) * 4 > 32'h1FFFF) o.free = '1;
    else o.free = 17'((lim - shadow_top[c]) * 4);
    return o;
  endfunction

  // plan one transaction: advance the planning copy and queue it
  task automatic add_item(input logic [1:0] op, input logic [15:0] req,
                          input logic [15:0] offs);
    alloc_req_t r;
    alloc_rsp_t unused;
    r.op = op;
    r.req = req;
    r.offs = offs;
    unused = alloc_step(PLAN, r);
    alloc_requests.push_back(r);
    n_added++;
  endtask

  // sender waits here until every planned transaction has its result
  task automatic drain();
    while (n_done != n_added) @(posedge clk);
  endtask

  // region size write: setup cycle, then access cycle; only while idle
  task automatic write_region(input int unsigned words);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REGION_ADDR;
    pwdata  <= 32'(words);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_region[PLAN] = words;
    shadow_region[LIVE] = words;
    n_settings++;
  endtask

  // random part: grow the stack in bursts, long ones run into the link
  // stack limit, then tear it down with removes and pops, with noise mixed in
  task automatic plan_random(input int n);
    int first;
    int k;
    int j;
    int r;
    first = n_added;
    while (n_added - first < n) begin
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
      for (j = 0; j < k; j++) begin
        r = $urandom_range(0, 99);
        if (r < 6) add_item(OP_QUERY, rand16(), rand16());
        else if (r < 12) add_item(OP_POP, rand16(), rand16());
        else if (r < 18) add_item(OP_PUSH, rand16(), rand16());
        else add_item(OP_PUSH, 16'($urandom_range(0, 255)), rand16());
      end
      k = $urandom_range(1, 10);
      for (j = 0; j < k; j++) begin
        r = $urandom_range(0, 99);
        if (r < 40 && shadow_count[PLAN] != 0)
          add_item(OP_REMOVE, rand16(),
                   {shadow_links[PLAN][$urandom_range(0, shadow_count[PLAN] - 1)], 2'b00});
        else if (r < 55) add_item(OP_REMOVE, rand16(), rand16());
        else if (r < 85) add_item(OP_POP, rand16(), rand16());
        else add_item(OP_QUERY, rand16(), rand16());
      end
    end
  endtask

  // request driver: a new transaction only once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        alloc_rsp_t pred;
        pred = alloc_step(LIVE, offered_req);
        expected_replies.push_back(pred);
        status_seen[pred.status]++;
      end
      if (!in_valid || in_ready) begin
        if (alloc_requests.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          offered_req = alloc_requests.pop_front();
          in_valid      <= 1'b1;
          opcode        <= offered_req.op;
          request_bytes <= offered_req.req;
          block_offset  <= offered_req.offs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("%0t: unexpected result status %0d offset %0d free %0d",
                     $realtime, status, granted_offset, free_bytes);
        end else begin
          alloc_rsp_t want;
          want = expected_replies.pop_front();
          n_done++;
          if (status !== want.status || granted_offset !== want.granted ||
              free_bytes !== want.free) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
              $display("%0t: mismatch, expected status %0d offset %0d free %0d, got %0d %0d %0d",
                       $realtime, want.status, want.granted, want.free,
                       status, granted_offset, free_bytes);
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // one long receiver hold-off so the dut backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end
  end

  // watchdog: cycles with work outstanding but no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (n_done == n_added && alloc_requests.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      shadow_region[c] = MAX_WORDS;
      shadow_top[c] = 0;
      shadow_count[c] = 0;
    end
    for (int s = 0; s < 5; s++) status_seen[s] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, sender idles often and receiver idles more
    add_item(OP_QUERY, 16'hFFFF, 16'hFFFF);
    add_item(OP_POP, 16'h0000, 16'h0000);       // pop on empty stack
    add_item(OP_REMOVE, 16'hFFFF, 16'h0000);    // remove with nothing live
    add_item(OP_PUSH, 16'h0000, 16'h0000);      // smallest block
    add_item(OP_PUSH, 16'hFFFF, 16'h0000);      // largest request, no fit
    add_item(OP_PUSH, 16'd65501, 16'h0000);     // new top lands on region end
    add_item(OP_PUSH, 16'd65500, 16'h0000);     // fits with one word pair left
    add_item(OP_PUSH, 16'h0000, 16'h0000);      // no room left
    add_item(OP_REMOVE, 16'h0000, 16'd16);
    add_item(OP_REMOVE, 16'h0000, 16'd3);       // not a block start
    add_item(OP_REMOVE, 16'h0000, 16'hFFFF);
    add_item(OP_PUSH, 16'd1, 16'h0000);
    add_item(OP_PUSH, 16'd5, 16'hFFFF);
    add_item(OP_POP, 16'hFFFF, 16'hFFFF);
    add_item(OP_REMOVE, 16'h0000, 16'h0000);    // frees every block
    add_item(OP_POP, 16'h0000, 16'h0000);
    drain();
    write_region(2);                            // smallest region
    add_item(OP_PUSH, 16'h0000, 16'h0000);
    add_item(OP_QUERY, 16'h0000, 16'h0000);
    drain();
    write_region(MAX_WORDS);
    add_item(OP_PUSH, 16'd1000, 16'h0000);
    add_item(OP_PUSH, 16'd1000, 16'h0000);
    add_item(OP_PUSH, 16'd1000, 16'h0000);
    drain();
    write_region(100);                          // region now below the top
    add_item(OP_QUERY, 16'h0000, 16'h0000);
    add_item(OP_PUSH, 16'h0000, 16'h0000);
    add_item(OP_POP, 16'h0000, 16'h0000);
    add_item(OP_REMOVE, 16'h0000, 16'h0000);
    drain();

    // random, full region, same idling
    write_region(MAX_WORDS);
    plan_random(PHASE_ITEMS);
    drain();

    // random, mid-size region, idling swapped
    src_idle_pct <= 79;
    snk_idle_pct <= 37;
    write_region($urandom_range(100, 1000) * 2);
    plan_random(PHASE_ITEMS);
    drain();

    // random, any even region size up to the full one, no idling, plus the long receiver hold-off
    src_idle_pct <= 0;
    snk_idle_pct <= 0;
    write_region($urandom_range(1, MAX_WORDS / 2) * 2);
    hold_armed <= 1'b1;
    plan_random(PHASE_ITEMS);
    drain();

    repeat (20) @(posedge clk);
    $display("covered %0d transactions over %0d region settings, %0d errors",
             n_added, n_settings, n_errors);
    $display("status mix: ok %0d, exhausted %0d, not found %0d, empty %0d, link full %0d",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_NOT_FOUND],
             status_seen[ST_EMPTY], status_seen[ST_LINK_FULL]);
    if (n_errors == 0 && expected_replies.size() == 0 && n_done == n_added)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
